// File: src/index_allocator_with_free_queue_assert.svh
// ----------------------------------------------------------------------------
// Index allocator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INDEX_ALLOCATOR_WITH_FREE_QUEUE_ASSERT_SVH
`define INDEX_ALLOCATOR_WITH_FREE_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define IA_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define IA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define IA_ASSERT(label, clk, rst_n, cond, msg)
`define IA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: src/ia_pkg.sv
// ----------------------------------------------------------------------------
// Index allocator package
// Shared constants, status codes and interface structs.
// ----------------------------------------------------------------------------
package ia_pkg;

  localparam int POOL_SIZE = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = IDX_W + 1;
  localparam int IDX_SPACE = 1 << IDX_W;
  localparam logic [CNT_W-1:0] USABLE_LIMIT =
    CNT_W'((POOL_SIZE < IDX_SPACE) ? POOL_SIZE : IDX_SPACE);
  localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(IDX_SPACE);

  typedef enum logic [2:0] {
    ST_REUSED    = 3'd0,
    ST_FRESH     = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_QUEUED    = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef struct packed {
    action_t          action;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    status_t          status;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             data;
  } flag_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } q_wr_t;

endpackage

// File: src/ia_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module ia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/ia_core.sv
// ----------------------------------------------------------------------------
// Index allocator core
// Queue pointers, fresh counter and the allocate/free decision.
// ----------------------------------------------------------------------------
`include "index_allocator_with_free_queue_assert.svh"

module ia_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  ia_pkg::req_t            req,
  input  logic                    flag_bit,
  input  logic [ia_pkg::IDX_W-1:0] head_data,
  output ia_pkg::rsp_t            rsp,
  output ia_pkg::flag_wr_t        flag_wr,
  output ia_pkg::q_wr_t           q_wr,
  output logic [ia_pkg::IDX_W-1:0] head_nxt
);

  logic [ia_pkg::IDX_W-1:0] head_r, tail_r, tail_nxt;
  logic [ia_pkg::CNT_W-1:0] count_r, count_nxt, fresh_r, fresh_nxt;
  logic                     reuse, fresh, enq;

  always_comb begin
    reuse = 1'b0;
    fresh = 1'b0;
    enq   = 1'b0;
    rsp.granted = '0;
    rsp.status  = ia_pkg::ST_EXHAUSTED;
    case (req.action)
      ia_pkg::ACT_ALLOC: begin
        if (count_r != '0) begin
          reuse = 1'b1;
          rsp.granted = head_data;
          rsp.status  = ia_pkg::ST_REUSED;
        end else if (fresh_r < ia_pkg::USABLE_LIMIT) begin
          fresh = 1'b1;
          rsp.granted = fresh_r[ia_pkg::IDX_W-1:0];
          rsp.status  = ia_pkg::ST_FRESH;
        end else begin
          rsp.status  = ia_pkg::ST_EXHAUSTED;
        end
      end
      ia_pkg::ACT_FREE: begin
        if (({1'b0, req.idx} >= ia_pkg::USABLE_LIMIT) || flag_bit ||
            (count_r >= ia_pkg::QUEUE_FULL)) begin
          rsp.status = ia_pkg::ST_IGNORED;
        end else begin
          enq = 1'b1;
          rsp.status = ia_pkg::ST_QUEUED;
        end
      end
      default: begin
        rsp.status = ia_pkg::ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    flag_wr.en   = fire && (reuse || enq);
    flag_wr.addr = reuse ? head_data : req.idx;
    flag_wr.data = enq;
    q_wr.en      = fire && enq;
    q_wr.addr    = tail_r;
    q_wr.data    = req.idx;
  end

  always_comb begin
    head_nxt  = (fire && reuse) ? head_r + 1'b1 : head_r;
    tail_nxt  = (fire && enq) ? tail_r + 1'b1 : tail_r;
    fresh_nxt = (fire && fresh) ? fresh_r + 1'b1 : fresh_r;
    count_nxt = count_r;
    if (fire && reuse) begin
      count_nxt = count_r - 1'b1;
    end else if (fire && enq) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      fresh_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  `IA_ASSERT(a_ring_count, clk, rst_n, (tail_r - head_r) == count_r[ia_pkg::IDX_W-1:0], "ring pointers disagree with count")
  `IA_ASSERT(a_count_max, clk, rst_n, count_r <= ia_pkg::QUEUE_FULL, "queue count overflow")
  `IA_ASSERT(a_fresh_max, clk, rst_n, fresh_r <= ia_pkg::USABLE_LIMIT, "fresh counter past limit")

endmodule

// File: src/index_allocator_with_free_queue.sv
// ----------------------------------------------------------------------------
// Index allocator with free queue
// An input transfer passes the input register and result register before
// out_tvalid rises. Throughput: one item per cycle unless out_tready stalls,
// via the single decision stage with prefetched queue head and bitmap read.
// After reset all 1024 bitmap RAM entries are swept clear with in_tready low.
// ----------------------------------------------------------------------------
module index_allocator_with_free_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] free_index, [15:10] zero
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] granted_index, [15:10] zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  logic                     accept, fire;
  logic                     s1_valid_r, s1_valid_nxt;
  ia_pkg::req_t             s1_req_r;
  logic                     out_valid_r;
  ia_pkg::rsp_t             out_rsp_r, rsp;

  logic                     clr_active_r;
  logic [ia_pkg::IDX_W-1:0] clr_cnt_r;

  ia_pkg::flag_wr_t         flag_wr;
  ia_pkg::q_wr_t            q_wr;
  logic                     fram_we, fram_wdata, fram_rdata, flag_bit;
  logic [ia_pkg::IDX_W-1:0] fram_waddr, fram_raddr;
  logic                     ffwd_v_r, ffwd_d_r;

  logic [ia_pkg::IDX_W-1:0] head_nxt, qram_rdata, head_data, qfwd_d_r;
  logic                     qfwd_v_r;

  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_active_r && (!s1_valid_r || fire);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r.action <= ia_pkg::action_t'(in_tuser);
      s1_req_r.idx    <= in_tdata[ia_pkg::IDX_W-1:0];
    end
  end

  // bitmap clear sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ia_pkg::IDX_W'(ia_pkg::IDX_SPACE - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign fram_we    = clr_active_r || flag_wr.en;
  assign fram_waddr = clr_active_r ? clr_cnt_r : flag_wr.addr;
  assign fram_wdata = clr_active_r ? 1'b0 : flag_wr.data;
  assign fram_raddr = accept ? in_tdata[ia_pkg::IDX_W-1:0] : s1_req_r.idx;

  ia_ram #(
    .WIDTH (1),
    .DEPTH (ia_pkg::IDX_SPACE)
  ) u_flag_ram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (fram_wdata),
    .raddr (fram_raddr),
    .rdata (fram_rdata)
  );

  // write-to-read bypass for same-cycle collisions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ffwd_v_r <= 1'b0;
      qfwd_v_r <= 1'b0;
    end else begin
      ffwd_v_r <= fram_we && (fram_waddr == fram_raddr);
      qfwd_v_r <= q_wr.en && (q_wr.addr == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    ffwd_d_r <= fram_wdata;
    qfwd_d_r <= q_wr.data;
  end

  assign flag_bit  = ffwd_v_r ? ffwd_d_r : fram_rdata;
  assign head_data = qfwd_v_r ? qfwd_d_r : qram_rdata;

  ia_ram #(
    .WIDTH (ia_pkg::IDX_W),
    .DEPTH (ia_pkg::IDX_SPACE)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_wr.en),
    .waddr (q_wr.addr),
    .wdata (q_wr.data),
    .raddr (head_nxt),
    .rdata (qram_rdata)
  );

  ia_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req       (s1_req_r),
    .flag_bit  (flag_bit),
    .head_data (head_data),
    .rsp       (rsp),
    .flag_wr   (flag_wr),
    .q_wr      (q_wr),
    .head_nxt  (head_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - ia_pkg::IDX_W){1'b0}}, out_rsp_r.granted};
  assign out_tuser  = out_rsp_r.status;

endmodule
